// ===== rtl/dpfc_pkg.sv =====
// Package for the deduplicating packet queue: sizes, operation codes and shared types.
package dpfc_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int CNT_W   = FILL_W;
  localparam int LIM_W   = 9;
  localparam int MC_W    = 9;
  localparam int LCMP_W  = (LIM_W > FILL_W) ? LIM_W : FILL_W;
  localparam int MCMP_W  = (CNT_W > MC_W) ? CNT_W : MC_W;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_COUNT   = 2'd2;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } pkt_t;

  typedef struct packed {
    logic        is_add;
    pkt_t        pkt;
    logic [31:0] t0;
    logic [31:0] t1;
  } query_t;

  typedef struct packed {
    logic occ;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/dpfc_cell.sv =====
// One queue slot: holds a packet, shifts toward the head, and adds its hit to the passing count.
module dpfc_cell (
  input  logic                        clk,
  input  dpfc_pkg::cell_ctrl_t        ctrl,
  input  dpfc_pkg::query_t            query,
  input  dpfc_pkg::pkt_t              nb_word,
  input  logic [dpfc_pkg::CNT_W-1:0]  acc_in,
  output dpfc_pkg::pkt_t              word,
  output logic [dpfc_pkg::CNT_W-1:0]  acc_out
);
  import dpfc_pkg::*;

  pkt_t             word_r;
  logic [CNT_W-1:0] acc_r;
  logic             hit;

  always_comb begin
    if (query.is_add) begin
      hit = ctrl.occ && (word_r == query.pkt);
    end else begin
      hit = ctrl.occ && (word_r.dst == query.pkt.dst) &&
            (word_r.ts >= query.t0) && (word_r.ts <= query.t1);
    end
  end

  // Load wins over shift: a new packet lands in the freed tail slot.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= query.pkt;
    end else if (ctrl.shift) begin
      word_r <= nb_word;
    end
    acc_r <= acc_in + CNT_W'(hit);
  end

  assign word    = word_r;
  assign acc_out = acc_r;

endmodule

// ===== rtl/dedup_packet_fifo_with_range_count_unit.sv =====
// Top level of the deduplicating packet queue with destination and time-range count.
//
// Command port: an operation word is taken at a rising edge with start high and busy
// low. in_kind selects add (0), forward (1) or count (2); kind 3 returns all zeros.
// Each command yields exactly one result word, shown for one cycle with out_strobe high;
// the receiver cannot stall and must take it in that cycle.
// Storage is a row of DEPTH identical cells in age order, the oldest at cell 0. Forward
// shifts every cell one place toward the head. Add and count broadcast the query to
// all cells; each cell compares its packet and adds its hit to a count that moves one
// cell per cycle through a register in every cell, so the total leaves the last cell.
// Add and count stay in ST_SCAN while the count crosses the cells, then go to ST_APPLY;
// forward and kind 3 go straight to ST_APPLY, which registers the result word. One
// command is in work at a time; busy is low in the strobe cycle, so the next command
// may be taken then.
// cfg_we writes memory_limit (0 acts as 1, above DEPTH acts as DEPTH); write it only
// while the block is idle. An add at the limit drops the oldest packet first.
// Reset empties the queue, sets memory_limit to 256 and clears busy and out_strobe.
module dedup_packet_fifo_with_range_count_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [15:0]                 in_source,
  input  logic [15:0]                 in_destination,
  input  logic [31:0]                 in_timestamp,
  input  logic [31:0]                 in_time_start,
  input  logic [31:0]                 in_time_end,
  input  logic                        cfg_we,
  input  logic [dpfc_pkg::LIM_W-1:0]  cfg_wdata,
  output logic                        out_strobe,
  output logic                        out_accepted,
  output logic                        out_packet_valid,
  output logic [15:0]                 out_source,
  output logic [15:0]                 out_destination,
  output logic [31:0]                 out_timestamp,
  output logic [dpfc_pkg::MC_W-1:0]   out_match_count
);
  import dpfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t            state_r;
  logic [1:0]        kind_r;
  query_t            query_r;
  logic [FILL_W-1:0] fill_r;
  logic [LIM_W-1:0]  limit_r;
  logic [IDX_W-1:0]  cnt_r;

  logic              strobe_r;
  logic              accepted_r;
  logic              pkt_valid_r;
  pkt_t              out_pkt_r;
  logic [MC_W-1:0]   match_r;

  pkt_t              words [DEPTH];
  logic [CNT_W-1:0]  acc [DEPTH+1];
  cell_ctrl_t        ctrl [DEPTH];

  logic [LCMP_W-1:0] lim_eff;
  logic              evict;
  logic              dup;
  logic              do_add;
  logic              do_pop;
  logic [FILL_W-1:0] load_idx;
  logic [MCMP_W-1:0] sum_w;
  logic [MC_W-1:0]   sum_sat;
  query_t            query_nxt;

  // Clamp the limit into 1..DEPTH.
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = LCMP_W'(1);
    end else if (LCMP_W'(limit_r) > LCMP_W'(DEPTH)) begin
      lim_eff = LCMP_W'(DEPTH);
    end else begin
      lim_eff = LCMP_W'(limit_r);
    end
  end

  assign evict    = LCMP_W'(fill_r) >= lim_eff;
  assign dup      = acc[DEPTH] != '0;
  assign do_add   = (state_r == ST_APPLY) && (kind_r == KIND_ADD) && !dup;
  assign do_pop   = (state_r == ST_APPLY) && (kind_r == KIND_FORWARD) && (fill_r != '0);
  assign load_idx = evict ? (fill_r - FILL_W'(1)) : fill_r;

  assign sum_w   = MCMP_W'(acc[DEPTH]);
  assign sum_sat = (sum_w > MCMP_W'({MC_W{1'b1}})) ? {MC_W{1'b1}} : sum_w[MC_W-1:0];

  // Per-cell control: occupancy, shift toward the head, load of the new packet.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].occ   = FILL_W'(i) < fill_r;
      ctrl[i].shift = do_pop || (do_add && evict);
      ctrl[i].load  = do_add && (FILL_W'(i) == load_idx);
    end
  end

  assign acc[0] = '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      dpfc_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl[g]),
        .query   (query_r),
        .nb_word ((g == DEPTH - 1) ? pkt_t'('0) : words[(g + 1) % DEPTH]),
        .acc_in  (acc[g]),
        .word    (words[g]),
        .acc_out (acc[g+1])
      );
    end
  endgenerate

  always_comb begin
    query_nxt.is_add  = in_kind == KIND_ADD;
    query_nxt.pkt.src = in_source;
    query_nxt.pkt.dst = in_destination;
    query_nxt.pkt.ts  = in_timestamp;
    query_nxt.t0      = in_time_start;
    query_nxt.t1      = in_time_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      limit_r  <= LIM_W'(256);
      strobe_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            kind_r  <= in_kind;
            query_r <= query_nxt;
            cnt_r   <= '0;
            // Forward and the unused kind need no scan.
            if ((in_kind == KIND_ADD) || (in_kind == KIND_COUNT)) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_APPLY;
            end
          end
        end
        ST_SCAN: begin
          // Hold the query until the count has crossed every cell.
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(DEPTH - 1)) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          strobe_r    <= 1'b1;
          accepted_r  <= do_add;
          pkt_valid_r <= do_pop;
          out_pkt_r   <= do_pop ? words[0] : pkt_t'('0);
          match_r     <= (kind_r == KIND_COUNT) ? sum_sat : '0;
          if (do_add && !evict) begin
            fill_r <= fill_r + FILL_W'(1);
          end else if (do_pop) begin
            fill_r <= fill_r - FILL_W'(1);
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = state_r != ST_IDLE;
  assign out_strobe       = strobe_r;
  assign out_accepted     = accepted_r;
  assign out_packet_valid = pkt_valid_r;
  assign out_source       = out_pkt_r.src;
  assign out_destination  = out_pkt_r.dst;
  assign out_timestamp    = out_pkt_r.ts;
  assign out_match_count  = match_r;

endmodule

// ===== rtl/dpfc_checker.sv =====
// Port-level checker for the packet queue, bound to the top level.
module dpfc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic                        out_accepted,
  input logic                        out_packet_valid,
  input logic [15:0]                 out_source,
  input logic [15:0]                 out_destination,
  input logic [31:0]                 out_timestamp,
  input logic [dpfc_pkg::MC_W-1:0]   out_match_count
);
  import dpfc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_accepted && out_packet_valid) &&
                   !(out_packet_valid && (out_match_count != '0)))
    else $error("result word mixes operations");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_packet_valid) |->
      (out_source == '0) && (out_destination == '0) && (out_timestamp == '0))
    else $error("packet fields nonzero without a popped packet");

endmodule

bind dedup_packet_fifo_with_range_count_unit dpfc_checker u_dpfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_accepted     (out_accepted),
  .out_packet_valid (out_packet_valid),
  .out_source       (out_source),
  .out_destination  (out_destination),
  .out_timestamp    (out_timestamp),
  .out_match_count  (out_match_count)
);
